>>> sv/mcd_pkg.sv
// Shared types and register indexes for the pointer click detector.
package mcd_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WIN_W = 16;
  localparam int POS_W = 16;
  localparam int TIME_W = 32;
  localparam int COUNT_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTI_CLICK_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MASK = 2'd2;

  localparam logic [WIN_W-1:0] CLICK_WINDOW_RST = 16'd250;
  localparam logic [WIN_W-1:0] MULTI_CLICK_WINDOW_RST = 16'd500;
  localparam logic [7:0] WHEEL_MASK_RST = 8'd24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic moved;
    logic pressed;
    logic released;
    logic clicked;
    logic hover;
    logic held_hint;
  } flags_t;

  typedef struct packed {
    logic [WIN_W-1:0] click_window;
    logic [WIN_W-1:0] multi_click_window;
  } windows_t;

endpackage

>>> sv/mcd_in_stage.sv
// Input register stage: captures one pointer report word per accepted handshake.
module mcd_in_stage #(
  parameter int BUTTON_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [15:0]      in_pos_x,
  input  logic signed [15:0]      in_pos_y,
  input  logic [BUTTON_BITS-1:0]  in_button_bits,
  input  logic [31:0]             in_time_ms,
  input  logic                    take,
  output logic                    valid_r,
  output logic signed [15:0]      pos_x_r,
  output logic signed [15:0]      pos_y_r,
  output logic [BUTTON_BITS-1:0]  button_bits_r,
  output logic [31:0]             time_ms_r
);
  import mcd_pkg::*;

  logic load;
  logic valid_nxt;

  assign in_stall = valid_r && !take;
  assign load = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos_x_r       <= in_pos_x;
      pos_y_r       <= in_pos_y;
      button_bits_r <= in_button_bits;
      time_ms_r     <= in_time_ms;
    end
  end

endmodule

>>> sv/mcd_classify.sv
// Report classifier: pointer and button state plus move/press/release/click decode.
module mcd_classify #(
  parameter int BUTTON_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  logic signed [15:0]      pos_x,
  input  logic signed [15:0]      pos_y,
  input  logic [BUTTON_BITS-1:0]  button_bits,
  input  logic [31:0]             time_ms,
  input  mcd_pkg::windows_t       windows,
  input  logic [BUTTON_BITS-1:0]  wheel_mask,
  output mcd_pkg::flags_t         flags,
  output logic [BUTTON_BITS-1:0]  changed_bits,
  output logic [7:0]              click_count
);
  import mcd_pkg::*;

  logic [POS_W-1:0]       cur_x_r, cur_y_r, press_x_r, press_y_r;
  logic [POS_W-1:0]       cur_x_nxt, cur_y_nxt, press_x_nxt, press_y_nxt;
  logic [BUTTON_BITS-1:0] stored_r, stored_nxt, press_bits_r, press_bits_nxt;
  logic [TIME_W-1:0]      last_report_r, last_click_r, last_click_nxt;
  logic [COUNT_W-1:0]     clicks_r, clicks_nxt;
  logic [TIME_W-1:0]      dt_report, dt_click;
  logic                   is_press, is_release, is_click, in_window, in_multi;
  logic [BUTTON_BITS-1:0] rel_bits;

  assign dt_report  = time_ms - last_report_r;
  assign dt_click   = time_ms - last_click_r;
  assign in_window  = dt_report <= {{(TIME_W-WIN_W){1'b0}}, windows.click_window};
  assign in_multi   = dt_click <= {{(TIME_W-WIN_W){1'b0}}, windows.multi_click_window};
  assign is_press   = button_bits > stored_r;
  assign is_release = button_bits < stored_r;
  assign rel_bits   = ~button_bits & stored_r;
  assign cur_x_nxt  = pos_x;
  assign cur_y_nxt  = pos_y;
  // press position compares against the updated pointer position
  assign is_click   = is_release && (button_bits == '0) && (rel_bits == press_bits_r) &&
                      (pos_x == press_x_r) && (pos_y == press_y_r) && in_window;

  always_comb begin
    press_bits_nxt = press_bits_r;
    press_x_nxt    = press_x_r;
    press_y_nxt    = press_y_r;
    clicks_nxt     = clicks_r;
    last_click_nxt = last_click_r;
    changed_bits   = '0;
    if (is_press) begin
      changed_bits   = button_bits & ~stored_r;
      press_bits_nxt = button_bits & ~stored_r;
      press_x_nxt    = pos_x;
      press_y_nxt    = pos_y;
    end else if (is_release) begin
      changed_bits = rel_bits;
      if (is_click) begin
        last_click_nxt = time_ms;
        if (!in_multi) begin
          clicks_nxt = COUNT_W'(1);
        end else if (clicks_r != COUNT_MAX) begin
          clicks_nxt = clicks_r + COUNT_W'(1);
        end
      end else begin
        clicks_nxt = '0;
      end
    end
  end

  assign stored_nxt = button_bits & ~wheel_mask;

  assign flags.moved     = (pos_x != cur_x_r) || (pos_y != cur_y_r);
  assign flags.pressed   = is_press;
  assign flags.released  = is_release;
  assign flags.clicked   = is_click;
  assign flags.hover     = !is_press && !is_release;
  assign flags.held_hint = !is_press && !is_release && (button_bits != '0);
  assign click_count     = clicks_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      stored_r      <= '0;
      press_bits_r  <= '0;
      press_x_r     <= '0;
      press_y_r     <= '0;
      last_report_r <= '0;
      last_click_r  <= '0;
      clicks_r      <= '0;
    end else if (fire) begin
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      stored_r      <= stored_nxt;
      press_bits_r  <= press_bits_nxt;
      press_x_r     <= press_x_nxt;
      press_y_r     <= press_y_nxt;
      last_report_r <= time_ms;
      last_click_r  <= last_click_nxt;
      clicks_r      <= clicks_nxt;
    end
  end

endmodule

>>> sv/mouse_click_detector_core.sv
// Pointer click detector top level: config registers, input stage, classifier, result register.
// Takes one pointer report per clock cycle while in_stall is low and gives one result word per
// report, through the input register and then classification into the result register. The
// classifier updates its per-report state as a report enters the result register, so reports
// may arrive back to back; a stalled result register holds the input register, and only then
// does in_stall rise. Configuration writes are always ready and take effect the next cycle.
module mouse_click_detector_core #(
  parameter int BUTTON_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [15:0]      in_pos_x,
  input  logic signed [15:0]      in_pos_y,
  input  logic [BUTTON_BITS-1:0]  in_button_bits,
  input  logic [31:0]             in_time_ms,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_moved,
  output logic                    out_pressed,
  output logic                    out_released,
  output logic                    out_clicked,
  output logic                    out_hover,
  output logic                    out_held_hint,
  output logic [BUTTON_BITS-1:0]  out_changed_bits,
  output logic [7:0]              out_click_count
);
  import mcd_pkg::*;

  windows_t               windows_r;
  logic [BUTTON_BITS-1:0] wheel_mask_r;
  logic                   cfg_wr;

  logic                   s0_valid_r;
  logic signed [15:0]     s0_pos_x_r, s0_pos_y_r;
  logic [BUTTON_BITS-1:0] s0_button_bits_r;
  logic [31:0]            s0_time_ms_r;

  logic                   out_free, fire;
  flags_t                 flags;
  logic [BUTTON_BITS-1:0] changed_bits;
  logic [7:0]             click_count;

  flags_t                 flags_r;
  logic [BUTTON_BITS-1:0] changed_bits_r;
  logic [7:0]             click_count_r;
  logic                   out_valid_r, out_valid_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      windows_r.click_window       <= CLICK_WINDOW_RST;
      windows_r.multi_click_window <= MULTI_CLICK_WINDOW_RST;
      wheel_mask_r                 <= BUTTON_BITS'(WHEEL_MASK_RST);
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_CLICK_WINDOW:       windows_r.click_window <= cfg_wdata;
        CFG_MULTI_CLICK_WINDOW: windows_r.multi_click_window <= cfg_wdata;
        CFG_WHEEL_MASK:         wheel_mask_r <= cfg_wdata[BUTTON_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s0_valid_r && out_free;

  mcd_in_stage #(
    .BUTTON_BITS(BUTTON_BITS)
  ) u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_button_bits(in_button_bits),
    .in_time_ms    (in_time_ms),
    .take          (out_free),
    .valid_r       (s0_valid_r),
    .pos_x_r       (s0_pos_x_r),
    .pos_y_r       (s0_pos_y_r),
    .button_bits_r (s0_button_bits_r),
    .time_ms_r     (s0_time_ms_r)
  );

  mcd_classify #(
    .BUTTON_BITS(BUTTON_BITS)
  ) u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .pos_x       (s0_pos_x_r),
    .pos_y       (s0_pos_y_r),
    .button_bits (s0_button_bits_r),
    .time_ms     (s0_time_ms_r),
    .windows     (windows_r),
    .wheel_mask  (wheel_mask_r),
    .flags       (flags),
    .changed_bits(changed_bits),
    .click_count (click_count)
  );

  assign out_valid_nxt = out_free ? s0_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      flags_r        <= flags;
      changed_bits_r <= changed_bits;
      click_count_r  <= click_count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_moved        = flags_r.moved;
  assign out_pressed      = flags_r.pressed;
  assign out_released     = flags_r.released;
  assign out_clicked      = flags_r.clicked;
  assign out_hover        = flags_r.hover;
  assign out_held_hint    = flags_r.held_hint;
  assign out_changed_bits = changed_bits_r;
  assign out_click_count  = click_count_r;

  a_one_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({flags_r.pressed, flags_r.released, flags_r.hover}))
    else $error("result is not exactly one of press, release, hover");

  a_click_is_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && flags_r.clicked) |-> (flags_r.released && click_count_r != '0))
    else $error("click without release or with zero count");

  a_change_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && flags_r.hover) |-> (changed_bits_r == '0))
    else $error("changed bits on unchanged buttons");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && out_valid_r && out_stall) |=> s0_valid_r)
    else $error("input register dropped a report under output stall");

endmodule

>>> tb/mouse_click_detector_core_tb.sv
// Self-checking testbench for the pointer click detector core.
`timescale 1ns / 1ps

module mouse_click_detector_core_tb;
  import mcd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic       moved;
    logic       pressed;
    logic       released;
    logic       clicked;
    logic       hover;
    logic       held_hint;
    logic [7:0] changed_bits;
    logic [7:0] click_count;
  } report_class_t;

  typedef struct packed {
    logic [15:0]   x;
    logic [15:0]   y;
    logic [7:0]    buttons;
    logic [31:0]   stamp;
    logic          fixed;
    report_class_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_pos_x;
  logic signed [15:0] in_pos_y;
  logic [7:0] in_button_bits;
  logic [31:0] in_time_ms;
  logic out_valid;
  logic out_stall;
  logic out_moved;
  logic out_pressed;
  logic out_released;
  logic out_clicked;
  logic out_hover;
  logic out_held_hint;
  logic [7:0] out_changed_bits;
  logic [7:0] out_click_count;

  // typed-in expectation that travels with the directed word on the bus
  logic row_fixed;
  report_class_t row_want;

  // predictor copy of the block state and registers
  logic [15:0] m_x = '0;
  logic [15:0] m_y = '0;
  logic [7:0]  m_buttons = '0;
  logic [7:0]  m_press_bits = '0;
  logic [15:0] m_press_x = '0;
  logic [15:0] m_press_y = '0;
  logic [31:0] m_last_report = '0;
  logic [31:0] m_last_click = '0;
  logic [7:0]  m_clicks = '0;
  logic [15:0] m_click_win = CLICK_WINDOW_RST;
  logic [15:0] m_multi_win = MULTI_CLICK_WINDOW_RST;
  logic [7:0]  m_wheel_mask = WHEEL_MASK_RST;

  report_class_t pending_reports[$];
  int err_count = 0;
  int n_seen = 0;
  bit idle_on = 1'b1;
  bit long_hold = 1'b0;
  logic [15:0] sx = '0;
  logic [15:0] sy = '0;
  logic [31:0] now_ms = '0;

  mouse_click_detector_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_button_bits(in_button_bits),
    .in_time_ms(in_time_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_moved(out_moved),
    .out_pressed(out_pressed),
    .out_released(out_released),
    .out_clicked(out_clicked),
    .out_hover(out_hover),
    .out_held_hint(out_held_hint),
    .out_changed_bits(out_changed_bits),
    .out_click_count(out_click_count)
  );

  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("mouse_click_detector_core_tb NOT OK");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    if (err_count < 40) begin
      $display("MISMATCH %s", msg);
    end
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("word %0d %s got %0h want %0h", n_seen, name, got, want));
    end
  endtask

  function automatic report_class_t classify_report(input logic [15:0] x, input logic [15:0] y,
                                                    input logic [7:0] b, input logic [31:0] now);
    report_class_t r;
    logic [7:0] prev;
    logic [31:0] since_report;
    logic [31:0] since_click;
    r = '0;
    prev = m_buttons;
    since_report = now - m_last_report;
    since_click = now - m_last_click;
    if (x != m_x || y != m_y) begin
      r.moved = 1'b1;
      m_x = x;
      m_y = y;
    end
    if (b > prev) begin
      r.pressed = 1'b1;
      r.changed_bits = b & ~prev;
      m_press_bits = r.changed_bits;
      m_press_x = m_x;
      m_press_y = m_y;
    end else if (b < prev) begin
      r.released = 1'b1;
      r.changed_bits = ~b & prev;
      if (b == 8'h00 && r.changed_bits == m_press_bits && m_x == m_press_x &&
          m_y == m_press_y && since_report <= {16'd0, m_click_win}) begin
        r.clicked = 1'b1;
        if (since_click <= {16'd0, m_multi_win}) begin
          if (m_clicks != COUNT_MAX) m_clicks = m_clicks + 8'd1;
        end else begin
          m_clicks = 8'd1;
        end
        m_last_click = now;
      end else begin
        m_clicks = 8'd0;
      end
    end else begin
      r.hover = 1'b1;
      r.held_hint = (b != 8'h00);
    end
    m_buttons = b & ~m_wheel_mask;
    m_last_report = now;
    r.click_count = m_clicks;
    return r;
  endfunction

  always @(posedge clk) begin
    report_class_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CLICK_WINDOW: m_click_win = cfg_wdata;
          CFG_MULTI_CLICK_WINDOW: m_multi_win = cfg_wdata;
          CFG_WHEEL_MASK: m_wheel_mask = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          note_mismatch($sformatf("word %0d arrived with nothing pending", n_seen));
        end else begin
          want = pending_reports.pop_front();
          check_field("moved", 8'(out_moved), 8'(want.moved));
          check_field("pressed", 8'(out_pressed), 8'(want.pressed));
          check_field("released", 8'(out_released), 8'(want.released));
          check_field("clicked", 8'(out_clicked), 8'(want.clicked));
          check_field("hover", 8'(out_hover), 8'(want.hover));
          check_field("held_hint", 8'(out_held_hint), 8'(want.held_hint));
          check_field("changed_bits", out_changed_bits, want.changed_bits);
          check_field("click_count", out_click_count, want.click_count);
        end
        n_seen++;
      end
      if (in_valid && !in_stall) begin
        want = classify_report(in_pos_x, in_pos_y, in_button_bits, in_time_ms);
        if (row_fixed) want = row_want;
        pending_reports.push_back(want);
      end
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (40) @(negedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_report(input logic [15:0] x, input logic [15:0] y, input logic [7:0] b,
                             input logic [31:0] t, input logic fixed = 1'b0,
                             input report_class_t want = '0);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_button_bits <= b;
    in_time_ms <= t;
    row_fixed <= fixed;
    row_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] time_step(input logic [15:0] win);
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return {16'd0, win};
      2: return {16'd0, win} + 32'd1;
      3: return -32'($urandom_range(1, 1000));
      4: return $urandom();
      default: return 32'($urandom_range(0, win));
    endcase
  endfunction

  // mostly press/release gestures; clean mode never breaks one
  task automatic random_traffic(input int n_items, input bit clean);
    int sent;
    logic [7:0] b;
    logic [15:0] px;
    sent = 0;
    while (sent < n_items) begin
      if (!clean && $urandom_range(0, 4) == 0) begin
        now_ms = now_ms + time_step(m_click_win);
        push_report(16'($urandom()), 16'($urandom()), 8'($urandom()), now_ms);
        sent++;
      end else begin
        if ($urandom_range(0, 1)) begin
          sx = 16'($urandom());
          sy = 16'($urandom());
        end
        b = $urandom_range(0, 1) ? 8'(1 << $urandom_range(0, 7)) : 8'($urandom_range(1, 255));
        now_ms = now_ms + (clean ? 32'($urandom_range(0, 1000)) : time_step(m_multi_win));
        push_report(sx, sy, b, now_ms);
        sent++;
        if (!clean && $urandom_range(0, 4) == 0) begin
          now_ms = now_ms + time_step(m_click_win);
          push_report(sx ^ 16'($urandom_range(1, 65535)), sy, b, now_ms);
          now_ms = now_ms + time_step(m_click_win);
          push_report(sx, sy, b, now_ms);
          sent += 2;
        end
        if (!clean && $urandom_range(0, 5) == 0) b = b & 8'($urandom());
        else b = 8'h00;
        px = sx;
        if (!clean && $urandom_range(0, 7) == 0) px = sx ^ 16'(1 << $urandom_range(0, 15));
        now_ms = now_ms + (clean ? 32'($urandom_range(0, 1000)) : time_step(m_click_win));
        push_report(px, sy, b, now_ms);
        sent++;
      end
    end
  endtask

  function automatic report_class_t cls(input bit mv, input bit pr, input bit rl, input bit ck,
                                        input bit hv, input bit hd, input logic [7:0] chg,
                                        input logic [7:0] cnt);
    return '{mv, pr, rl, ck, hv, hd, chg, cnt};
  endfunction

  function automatic dir_row_t row(input logic [15:0] x, input logic [15:0] y,
                                   input logic [7:0] b, input logic [31:0] t,
                                   input logic fixed = 1'b0, input report_class_t want = '0);
    return '{x, y, b, t, fixed, want};
  endfunction

  initial begin
    dir_row_t plan[$];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_button_bits = '0;
    in_time_ms = '0;
    row_fixed = 1'b0;
    row_want = '0;

    plan.push_back(row(16'h0000, 16'h0000, 8'h00, 32'd0, 1'b1, cls(0, 0, 0, 0, 1, 0, 0, 0)));
    plan.push_back(row(16'h7FFF, 16'h8000, 8'h00, 32'd5, 1'b1, cls(1, 0, 0, 0, 1, 0, 0, 0)));
    plan.push_back(row(16'h7FFF, 16'h8000, 8'h01, 32'd10, 1'b1,
                       cls(0, 1, 0, 0, 0, 0, 8'h01, 0)));
    plan.push_back(row(16'h7FFF, 16'h8000, 8'h00, 32'd60));
    plan.push_back(row(16'h7FFF, 16'h8000, 8'h01, 32'd100));
    plan.push_back(row(16'h7FFF, 16'h8000, 8'h00, 32'd150));
    // hold, drag, and release away from the press point
    plan.push_back(row(16'h8000, 16'h7FFF, 8'h80, 32'd200));
    plan.push_back(row(16'h8000, 16'h7FFF, 8'h80, 32'd210));
    plan.push_back(row(16'h0000, 16'h0001, 8'h80, 32'd220));
    plan.push_back(row(16'h0000, 16'h0001, 8'h00, 32'd230));
    // all buttons, wheel bits dropped from stored state, partial and mixed changes
    plan.push_back(row(16'h0000, 16'h0001, 8'hFF, 32'd240));
    plan.push_back(row(16'h0000, 16'h0001, 8'hFF, 32'd250));
    plan.push_back(row(16'h0000, 16'h0001, 8'h03, 32'd260));
    plan.push_back(row(16'h0000, 16'h0001, 8'h01, 32'd270));
    plan.push_back(row(16'h0000, 16'h0001, 8'h02, 32'd280));
    plan.push_back(row(16'h0000, 16'h0001, 8'h01, 32'd290));
    plan.push_back(row(16'h0000, 16'h0001, 8'h00, 32'd300));
    // timestamp wrap, stale timestamp, window edges
    plan.push_back(row(16'h0000, 16'h0001, 8'h04, 32'hFFFF_FFFF));
    plan.push_back(row(16'h0000, 16'h0001, 8'h00, 32'h0000_0010));
    plan.push_back(row(16'h0000, 16'h0001, 8'h04, 32'h0000_0100));
    plan.push_back(row(16'h0000, 16'h0001, 8'h00, 32'h0000_00F0));
    plan.push_back(row(16'h0000, 16'h0001, 8'h04, 32'h0000_1000));
    plan.push_back(row(16'h0000, 16'h0001, 8'h00, 32'h0000_1000 + 32'd251));
    plan.push_back(row(16'h0000, 16'h0001, 8'h04, 32'h0000_2000));
    plan.push_back(row(16'h0000, 16'h0001, 8'h00, 32'h0000_2000 + 32'd250));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      push_report(plan[i].x, plan[i].y, plan[i].buttons, plan[i].stamp,
                  plan[i].fixed, plan[i].want);
    end
    now_ms = 32'h0000_3000;
    settle();

    write_reg(CFG_CLICK_WINDOW, 16'd0);
    write_reg(CFG_MULTI_CLICK_WINDOW, 16'd0);
    write_reg(CFG_WHEEL_MASK, {8'($urandom()), 8'hFF});
    write_reg(CFG_SPARE, 16'($urandom()));
    random_traffic(60, 1'b0);
    settle();

    // widest windows, no wheel mask: chain enough clicks to pin the count
    write_reg(CFG_CLICK_WINDOW, 16'hFFFF);
    write_reg(CFG_MULTI_CLICK_WINDOW, 16'hFFFF);
    write_reg(CFG_WHEEL_MASK, {8'($urandom()), 8'h00});
    long_hold = 1'b1;
    random_traffic(520, 1'b1);
    settle();

    write_reg(CFG_CLICK_WINDOW, 16'($urandom_range(0, 2000)));
    write_reg(CFG_MULTI_CLICK_WINDOW, 16'($urandom_range(0, 4000)));
    write_reg(CFG_WHEEL_MASK, 16'($urandom()));
    random_traffic(60, 1'b0);
    settle();

    write_reg(CFG_CLICK_WINDOW, CLICK_WINDOW_RST);
    write_reg(CFG_MULTI_CLICK_WINDOW, MULTI_CLICK_WINDOW_RST);
    write_reg(CFG_WHEEL_MASK, {8'h00, WHEEL_MASK_RST});
    idle_on = 1'b0;
    random_traffic(40, 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("mouse_click_detector_core_tb OK");
    end else begin
      $display("mouse_click_detector_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
sv/mcd_pkg.sv
sv/mcd_in_stage.sv
sv/mcd_classify.sv
sv/mouse_click_detector_core.sv
tb/mouse_click_detector_core_tb.sv
